// ----- rtl/keyframe_aware_drop_queue_unit_defines.svh -----
// Assertion macros used by the checker of the frame drop queue.
`ifndef KEYFRAME_AWARE_DROP_QUEUE_UNIT_DEFINES_SVH
`define KEYFRAME_AWARE_DROP_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KADQ_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KADQ_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kadq_pkg.sv -----
// Types, constants and helper functions of the frame drop queue.
package kadq_pkg;

    localparam int QUEUE_DEPTH  = 32;
    localparam int TAG_BITS     = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int RESULT_BOUND = 32;

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W   = 6;
    localparam int LIMIT_W = 6;
    localparam int DROP_W  = 32;

    typedef logic [TAG_BITS-1:0]     tag_t;
    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [OCC_W-1:0]        occ_t;
    typedef logic [LIMIT_W-1:0]      lim_t;
    typedef logic [DROP_W-1:0]       drop_t;

    typedef enum logic [1:0] {
        MODE_PUSH      = 2'd0,
        MODE_POP_ONE   = 2'd1,
        MODE_POP_BATCH = 2'd2,
        MODE_SHUTDOWN  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SAME  = 2'd1,
        ACT_OTHER = 2'd2,
        ACT_DROP  = 2'd3
    } act_t;

    localparam cnt_t CNT_DEPTH = cnt_t'(QUEUE_DEPTH);
    localparam logic [ADDR_W:0] DEPTH_A = (ADDR_W + 1)'(QUEUE_DEPTH);
    localparam lim_t CAP_RESET = lim_t'(32);

    typedef struct packed {
        logic  key;
        chan_t chan;
        tag_t  tag;
    } entry_t;

    typedef struct packed {
        logic   accepted;
        logic   has_frame;
        entry_t ent;
        logic   last;
        act_t   drop_action;
        occ_t   occupancy;
        drop_t  dropped;
        logic   closed;
    } result_t;

    typedef struct packed {
        logic  clear;
        logic  issue;
        addr_t idx;
    } scan_ctl_t;

    typedef struct packed {
        logic  pending;
        logic  same_found;
        addr_t same_idx;
        logic  any_found;
        addr_t any_idx;
    } scan_res_t;

    // Ring buffer address arithmetic: both operands lie below the depth.
    function automatic addr_t wrap_add(addr_t base, addr_t off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_A)
        begin
            sum = sum - DEPTH_A;
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/kadq_if.sv -----
// Valid/ready channel interfaces for the request and result beats.
interface kadq_in_if;
    logic                 valid;
    logic                 ready;
    kadq_pkg::mode_t      mode;
    kadq_pkg::tag_t       frame_tag;
    kadq_pkg::chan_t      channel;
    logic                 keyframe;
    kadq_pkg::lim_t       batch_limit;

    modport source (output valid, mode, frame_tag, channel, keyframe, batch_limit,
                    input ready);
    modport sink   (input valid, mode, frame_tag, channel, keyframe, batch_limit,
                    output ready);
endinterface

interface kadq_out_if;
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic                 has_frame;
    kadq_pkg::tag_t       out_tag;
    kadq_pkg::chan_t      out_channel;
    logic                 out_keyframe;
    logic                 last;
    kadq_pkg::act_t       drop_action;
    kadq_pkg::occ_t       occupancy;
    kadq_pkg::drop_t      dropped_total;
    logic                 closed;

    modport source (output valid, accepted, has_frame, out_tag, out_channel,
                    out_keyframe, last, drop_action, occupancy, dropped_total, closed,
                    input ready);
    modport sink   (input valid, accepted, has_frame, out_tag, out_channel,
                    out_keyframe, last, drop_action, occupancy, dropped_total, closed,
                    output ready);
endinterface

// ----- rtl/kadq_ram.sv -----
// Descriptor store: one write port and one registered read port.
module kadq_ram
(
    input  logic             clk,
    input  logic             we,
    input  kadq_pkg::addr_t  waddr,
    input  kadq_pkg::entry_t wdata,
    input  kadq_pkg::addr_t  raddr,
    output kadq_pkg::entry_t rdata
);

    kadq_pkg::entry_t mem [kadq_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/kadq_scan.sv -----
// Shared compare unit: finds the oldest non-keyframe, overall and of one channel.
module kadq_scan
(
    input  logic                clk,
    input  logic                rst_n,
    input  kadq_pkg::scan_ctl_t ctl,
    input  kadq_pkg::entry_t    rdata,
    input  kadq_pkg::chan_t     chan,
    output kadq_pkg::scan_res_t res
);

    logic            pending_reg;
    kadq_pkg::addr_t pidx_reg;
    logic            same_found_reg;
    logic            same_found_next;
    kadq_pkg::addr_t same_idx_reg;
    kadq_pkg::addr_t same_idx_next;
    logic            any_found_reg;
    logic            any_found_next;
    kadq_pkg::addr_t any_idx_reg;
    kadq_pkg::addr_t any_idx_next;
    logic            hit_any;
    logic            hit_same;

    // The read data lines up with the index issued in the previous cycle.
    assign hit_any  = pending_reg && !rdata.key;
    assign hit_same = hit_any && (rdata.chan == chan);

    always_comb
    begin
        same_found_next = same_found_reg;
        same_idx_next   = same_idx_reg;
        any_found_next  = any_found_reg;
        any_idx_next    = any_idx_reg;
        if (ctl.clear)
        begin
            same_found_next = 1'b0;
            any_found_next  = 1'b0;
        end
        else
        begin
            if (hit_same && !same_found_reg)
            begin
                same_found_next = 1'b1;
                same_idx_next   = pidx_reg;
            end
            if (hit_any && !any_found_reg)
            begin
                any_found_next = 1'b1;
                any_idx_next   = pidx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            same_found_reg <= 1'b0;
            any_found_reg  <= 1'b0;
        end
        else
        begin
            pending_reg    <= ctl.issue;
            same_found_reg <= same_found_next;
            any_found_reg  <= any_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg     <= ctl.idx;
        same_idx_reg <= same_idx_next;
        any_idx_reg  <= any_idx_next;
    end

    assign res.pending    = pending_reg;
    assign res.same_found = same_found_reg;
    assign res.same_idx   = same_idx_reg;
    assign res.any_found  = any_found_reg;
    assign res.any_idx    = any_idx_reg;

endmodule

// ----- rtl/kadq_ctrl.sv -----
// Sequencer of the frame drop queue: push policy, pops and the result register.
module kadq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  kadq_pkg::cnt_t      cap_eff,
    kadq_in_if.sink             req,
    kadq_out_if.source          rsp,
    output logic                ram_we,
    output kadq_pkg::addr_t     ram_waddr,
    output kadq_pkg::entry_t    ram_wdata,
    output kadq_pkg::addr_t     ram_raddr,
    input  kadq_pkg::entry_t    ram_rdata,
    output kadq_pkg::scan_ctl_t scan_ctl,
    input  kadq_pkg::scan_res_t scan_res,
    output kadq_pkg::chan_t     scan_chan
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SCAN    = 8'b0000_0010,
        S_COPY_RD = 8'b0000_0100,
        S_COPY_WR = 8'b0000_1000,
        S_INSERT  = 8'b0001_0000,
        S_POP_RD  = 8'b0010_0000,
        S_POP_OUT = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    kadq_pkg::cnt_t    count_reg;
    kadq_pkg::cnt_t    count_next;
    kadq_pkg::addr_t   head_reg;
    kadq_pkg::addr_t   head_next;
    logic              closed_reg;
    logic              closed_next;
    kadq_pkg::drop_t   drop_reg;
    kadq_pkg::drop_t   drop_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    kadq_pkg::result_t out_res_reg;
    kadq_pkg::result_t out_res_next;
    kadq_pkg::entry_t  ent_reg;
    kadq_pkg::entry_t  ent_next;
    kadq_pkg::cnt_t    n_reg;
    kadq_pkg::cnt_t    n_next;
    kadq_pkg::cnt_t    k_reg;
    kadq_pkg::cnt_t    k_next;
    kadq_pkg::cnt_t    idx_reg;
    kadq_pkg::cnt_t    idx_next;
    logic              res_acc_reg;
    logic              res_acc_next;
    kadq_pkg::act_t    res_act_reg;
    kadq_pkg::act_t    res_act_next;
    logic              out_free;
    kadq_pkg::cnt_t    bat_n;
    kadq_pkg::addr_t   evict_pos;
    logic              last_beat;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign scan_chan = ent_reg.chan;
    assign last_beat = ((k_reg + kadq_pkg::cnt_t'(1)) == n_reg);

    // Batch size: limited by the request, the fill and the result bound.
    always_comb
    begin
        if (int'(req.batch_limit) < int'(count_reg))
        begin
            bat_n = kadq_pkg::cnt_t'(req.batch_limit);
        end
        else
        begin
            bat_n = count_reg;
        end
        if (int'(bat_n) > kadq_pkg::RESULT_BOUND)
        begin
            bat_n = kadq_pkg::cnt_t'(kadq_pkg::RESULT_BOUND);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        closed_next    = closed_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        ent_next       = ent_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        res_acc_next   = res_acc_reg;
        res_act_next   = res_act_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = ent_reg;
        ram_raddr      = head_reg;
        scan_ctl       = '0;
        evict_pos      = scan_res.any_idx;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ent_next.key  = req.keyframe;
                    ent_next.chan = req.channel;
                    ent_next.tag  = req.frame_tag;
                    res_acc_next  = 1'b0;
                    res_act_next  = kadq_pkg::ACT_NONE;
                    case (req.mode)
                        kadq_pkg::MODE_PUSH:
                        begin
                            if (closed_reg)
                            begin
                                state_next = S_FIN;
                            end
                            else if (count_reg >= cap_eff)
                            begin
                                idx_next       = '0;
                                scan_ctl.clear = 1'b1;
                                state_next     = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_INSERT;
                            end
                        end
                        kadq_pkg::MODE_POP_ONE:
                        begin
                            n_next = kadq_pkg::cnt_t'(1);
                            k_next = '0;
                            if (count_reg == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_POP_RD;
                            end
                        end
                        kadq_pkg::MODE_POP_BATCH:
                        begin
                            n_next = bat_n;
                            k_next = '0;
                            if (bat_n == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_POP_RD;
                            end
                        end
                        default:
                        begin
                            closed_next = 1'b1;
                            state_next  = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_raddr      = kadq_pkg::wrap_add(head_reg,
                                                        idx_reg[kadq_pkg::ADDR_W-1:0]);
                    scan_ctl.issue = 1'b1;
                    scan_ctl.idx   = idx_reg[kadq_pkg::ADDR_W-1:0];
                    idx_next       = idx_reg + kadq_pkg::cnt_t'(1);
                end
                else if (!scan_res.pending)
                begin
                    if (drop_reg != '1)
                    begin
                        drop_next = drop_reg + kadq_pkg::drop_t'(1);
                    end
                    if (scan_res.same_found || scan_res.any_found)
                    begin
                        if (scan_res.same_found)
                        begin
                            evict_pos    = scan_res.same_idx;
                            res_act_next = kadq_pkg::ACT_SAME;
                        end
                        else
                        begin
                            res_act_next = kadq_pkg::ACT_OTHER;
                        end
                        idx_next = kadq_pkg::cnt_t'(evict_pos);
                        if ((kadq_pkg::cnt_t'(evict_pos) + kadq_pkg::cnt_t'(1)) < count_reg)
                        begin
                            state_next = S_COPY_RD;
                        end
                        else
                        begin
                            count_next = count_reg - kadq_pkg::cnt_t'(1);
                            state_next = S_INSERT;
                        end
                    end
                    else
                    begin
                        res_act_next = kadq_pkg::ACT_DROP;
                        state_next   = S_FIN;
                    end
                end
            end

            S_COPY_RD:
            begin
                ram_raddr  = kadq_pkg::wrap_add(head_reg,
                                 kadq_pkg::addr_t'(idx_reg + kadq_pkg::cnt_t'(1)));
                state_next = S_COPY_WR;
            end

            S_COPY_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = kadq_pkg::wrap_add(head_reg, idx_reg[kadq_pkg::ADDR_W-1:0]);
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + kadq_pkg::cnt_t'(1);
                if ((idx_reg + kadq_pkg::cnt_t'(2)) < count_reg)
                begin
                    state_next = S_COPY_RD;
                end
                else
                begin
                    count_next = count_reg - kadq_pkg::cnt_t'(1);
                    state_next = S_INSERT;
                end
            end

            S_INSERT:
            begin
                if (count_reg < kadq_pkg::CNT_DEPTH)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = kadq_pkg::wrap_add(head_reg,
                                                    count_reg[kadq_pkg::ADDR_W-1:0]);
                    ram_wdata  = ent_reg;
                    count_next = count_reg + kadq_pkg::cnt_t'(1);
                end
                res_acc_next = 1'b1;
                state_next   = S_FIN;
            end

            S_POP_RD:
            begin
                state_next = S_POP_OUT;
            end

            S_POP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_res_next.accepted    = 1'b0;
                    out_res_next.has_frame   = 1'b1;
                    out_res_next.ent         = ram_rdata;
                    out_res_next.last        = last_beat;
                    out_res_next.drop_action = kadq_pkg::ACT_NONE;
                    out_res_next.occupancy   =
                        kadq_pkg::occ_t'(count_reg - kadq_pkg::cnt_t'(1));
                    out_res_next.dropped     = drop_reg;
                    out_res_next.closed      = closed_reg;
                    head_next  = kadq_pkg::wrap_add(head_reg, kadq_pkg::addr_t'(1));
                    count_next = count_reg - kadq_pkg::cnt_t'(1);
                    k_next     = k_reg + kadq_pkg::cnt_t'(1);
                    if (last_beat)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_POP_RD;
                    end
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_res_next.accepted    = res_acc_reg;
                    out_res_next.has_frame   = 1'b0;
                    out_res_next.ent         = '0;
                    out_res_next.last        = 1'b1;
                    out_res_next.drop_action = res_act_reg;
                    out_res_next.occupancy   = kadq_pkg::occ_t'(count_reg);
                    out_res_next.dropped     = drop_reg;
                    out_res_next.closed      = closed_reg;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            closed_reg    <= 1'b0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            closed_reg    <= closed_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        ent_reg     <= ent_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        res_acc_reg <= res_acc_next;
        res_act_reg <= res_act_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted      = out_res_reg.accepted;
    assign rsp.has_frame     = out_res_reg.has_frame;
    assign rsp.out_tag       = out_res_reg.ent.tag;
    assign rsp.out_channel   = out_res_reg.ent.chan;
    assign rsp.out_keyframe  = out_res_reg.ent.key;
    assign rsp.last          = out_res_reg.last;
    assign rsp.drop_action   = out_res_reg.drop_action;
    assign rsp.occupancy     = out_res_reg.occupancy;
    assign rsp.dropped_total = out_res_reg.dropped;
    assign rsp.closed        = out_res_reg.closed;

endmodule

// ----- rtl/keyframe_aware_drop_queue_unit.sv -----
// Top level of the keyframe-aware frame descriptor drop queue.
//
// Usage: frame descriptors and commands arrive as beats on req (push, pop one,
// pop batch, shutdown); every command produces one or more result beats on rsp,
// the last of which carries last = 1. The capacity register is loaded through
// cfg_wen/cfg_wdata and clamps to the queue depth; the user must write it only
// while the block is idle; the block does not enforce this. The block takes one
// command at a time: req.ready is high only in the idle state. A push below
// capacity goes through the insert state; a pop reads the store once per entry
// through the pop read and pop output states. A push at capacity first scans
// every held entry through the shared compare unit, then drops the new frame if
// no non-keyframe is held, or closes the gap left by the evicted entry with one
// read and one write per entry behind it, as the store has a single registered
// read port and a single write port. Reset clears the fill count, the closed
// flag, the drop counter and the result valid flag, and restores the capacity
// to its reset value; the store needs no clearing since only held entries are
// ever read. When the receiver stalls, the result register holds its beat and
// the sequencer waits before loading the next, so nothing is lost; a new
// command can still be accepted while a finished result waits to be taken.
module keyframe_aware_drop_queue_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  kadq_pkg::lim_t    cfg_wdata,
    kadq_in_if.sink           req,
    kadq_out_if.source        rsp
);

    kadq_pkg::lim_t      cap_reg;
    kadq_pkg::cnt_t      cap_eff;
    logic                ram_we;
    kadq_pkg::addr_t     ram_waddr;
    kadq_pkg::entry_t    ram_wdata;
    kadq_pkg::addr_t     ram_raddr;
    kadq_pkg::entry_t    ram_rdata;
    kadq_pkg::scan_ctl_t scan_ctl;
    kadq_pkg::scan_res_t scan_res;
    kadq_pkg::chan_t     scan_chan;

    // Capacity, unguarded; the user must write only while the block is idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= kadq_pkg::CAP_RESET;
        end
        else if (cfg_wen)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // A capacity above the physical depth behaves as the depth itself.
    always_comb
    begin
        if (int'(cap_reg) > kadq_pkg::QUEUE_DEPTH)
        begin
            cap_eff = kadq_pkg::CNT_DEPTH;
        end
        else
        begin
            cap_eff = kadq_pkg::cnt_t'(cap_reg);
        end
    end

    kadq_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kadq_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .rdata (ram_rdata),
        .chan  (scan_chan),
        .res   (scan_res)
    );

    kadq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_eff   (cap_eff),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .scan_ctl  (scan_ctl),
        .scan_res  (scan_res),
        .scan_chan (scan_chan)
    );

endmodule

// ----- rtl/kadq_checker.sv -----
// Port-level checker of the frame drop queue and its bind to the top level.
`include "keyframe_aware_drop_queue_unit_defines.svh"

module kadq_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic            out_accepted,
    input logic            out_has_frame,
    input kadq_pkg::tag_t  out_tag,
    input logic            out_last,
    input kadq_pkg::act_t  out_drop_action,
    input kadq_pkg::drop_t out_dropped_total,
    input logic            out_closed
);

    // One command at a time: the block is busy right after taking a beat.
    `KADQ_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // A stalled result beat keeps its contents.
    `KADQ_CHECK_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_tag) && $stable(out_last) && $stable(out_dropped_total), "stalled beat changed")

    // A stored push never comes from a closed queue and never drops itself.
    `KADQ_CHECK_SAME(a_accept_sane, out_valid && out_accepted, !out_has_frame && !out_closed && out_drop_action != kadq_pkg::ACT_DROP, "bad accepted beat")

    // Popped frames carry no push outcome.
    `KADQ_CHECK_SAME(a_pop_clean, out_valid && out_has_frame, !out_accepted && out_drop_action == kadq_pkg::ACT_NONE, "bad popped beat")

endmodule

bind keyframe_aware_drop_queue_unit kadq_checker u_kadq_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (req.valid),
    .in_ready          (req.ready),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_accepted      (rsp.accepted),
    .out_has_frame     (rsp.has_frame),
    .out_tag           (rsp.out_tag),
    .out_last          (rsp.last),
    .out_drop_action   (rsp.drop_action),
    .out_dropped_total (rsp.dropped_total),
    .out_closed        (rsp.closed)
);
